// ===== hw/rtl/lphm_pkg.sv =====
package lphm_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int HASH_W         = 10;
    localparam int KEY_W          = 64;
    localparam int VAL_W          = 64;
    localparam int CNT_W          = 11;
    localparam int ST_W           = 3;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 11'd614;

    // register index is paddr[2]
    localparam logic REG_FILL_LIMIT = 1'b0;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_ZERO_KEY  = 3'd5;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [HASH_W-1:0] hash_index;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] found_value;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_wr_ctl;

    typedef struct packed {
        logic hit;
        logic empty;
        logic last_probe;
        logic at_end;
    } t_probe_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_PROBE
    } t_state;

endpackage

// ===== hw/rtl/lphm_store.sv =====
module lphm_store #(
    parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  lphm_pkg::t_wr_ctl          i_wr,
    input  logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  logic [lphm_pkg::KEY_W-1:0] i_wkey,
    input  logic [lphm_pkg::VAL_W-1:0] i_wval,
    input  logic [$clog2(CAPACITY)-1:0] i_raddr,
    output logic [lphm_pkg::KEY_W-1:0] o_rkey,
    output logic [lphm_pkg::VAL_W-1:0] o_rval
);

    logic [lphm_pkg::KEY_W-1:0] r_key_mem [CAPACITY];
    logic [lphm_pkg::VAL_W-1:0] r_val_mem [CAPACITY];
    logic [lphm_pkg::KEY_W-1:0] r_rkey;
    logic [lphm_pkg::VAL_W-1:0] r_rval;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        r_rkey <= r_key_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_waddr] <= i_wval;
        end
        r_rval <= r_val_mem[i_raddr];
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

// ===== hw/rtl/lphm_probe.sv =====
module lphm_probe #(
    parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
    input  logic [$clog2(CAPACITY)-1:0] i_idx,
    input  logic [$clog2(CAPACITY)-1:0] i_cnt,
    input  logic [lphm_pkg::KEY_W-1:0]  i_stored_key,
    input  logic [lphm_pkg::KEY_W-1:0]  i_key,
    output logic [$clog2(CAPACITY)-1:0] o_next_idx,
    output logic [$clog2(CAPACITY)-1:0] o_next_cnt,
    output lphm_pkg::t_probe_res        o_res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

    always_comb begin
        o_res.hit        = (i_stored_key == i_key);
        o_res.empty      = (i_stored_key == '0);
        o_res.at_end     = (i_idx == LAST_SLOT);
        o_res.last_probe = (i_cnt == LAST_SLOT);
        o_next_idx       = o_res.at_end ? '0 : i_idx + IDX_W'(1);
        o_next_cnt       = i_cnt + IDX_W'(1);
    end

endmodule

// ===== hw/rtl/lphm_seq.sv =====
module lphm_seq #(
    parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  lphm_pkg::t_req              i_req,
    input  logic [lphm_pkg::CNT_W-1:0]  i_fill_limit,
    input  logic [lphm_pkg::KEY_W-1:0]  i_rkey,
    input  logic [lphm_pkg::VAL_W-1:0]  i_rval,
    input  logic [$clog2(CAPACITY)-1:0] i_next_idx,
    input  logic [$clog2(CAPACITY)-1:0] i_next_cnt,
    input  lphm_pkg::t_probe_res        i_pres,
    output logic [$clog2(CAPACITY)-1:0] o_idx,
    output logic [$clog2(CAPACITY)-1:0] o_cnt,
    output logic [lphm_pkg::KEY_W-1:0]  o_key,
    output lphm_pkg::t_wr_ctl           o_wr,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [lphm_pkg::KEY_W-1:0]  o_wkey,
    output logic [lphm_pkg::VAL_W-1:0]  o_wval,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    output logic                        o_busy,
    output logic                        o_done,
    output lphm_pkg::t_rsp              o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int RW    = (IDX_W > lphm_pkg::HASH_W) ? IDX_W : lphm_pkg::HASH_W;
    localparam int CW    = RW + 1;

    lphm_pkg::t_state            r_state, n_state;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [IDX_W-1:0]            r_cnt, n_cnt;
    logic [RW-1:0]               r_red, n_red;
    lphm_pkg::t_req              r_req, n_req;
    logic [lphm_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_done, n_done;
    lphm_pkg::t_rsp              r_rsp, n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lphm_pkg::S_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_red <= n_red;
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_red   = r_red;
        n_req   = r_req;
        n_count = r_count;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        o_wr    = '0;
        o_waddr = r_idx;
        o_wkey  = r_req.key;
        o_wval  = r_req.value;
        o_raddr = r_idx;

        case (r_state)
            lphm_pkg::S_CLEAR: begin
                // sweep the key memory to empty, one slot a cycle
                o_wr.key_we = 1'b1;
                o_wkey      = '0;
                n_idx       = i_next_idx;
                if (i_pres.at_end) begin
                    n_state = lphm_pkg::S_IDLE;
                end
            end
            lphm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.key == '0) begin
                        n_done            = 1'b1;
                        n_rsp.status      = lphm_pkg::ST_ZERO_KEY;
                        n_rsp.found_value = '0;
                        n_rsp.entry_count = r_count;
                    end else begin
                        n_red   = RW'(i_req.hash_index);
                        n_state = lphm_pkg::S_REDUCE;
                    end
                end
            end
            lphm_pkg::S_REDUCE: begin
                // start slot is the hash index modulo the capacity
                if ({1'b0, r_red} >= CW'(CAPACITY)) begin
                    n_red = r_red - RW'(CAPACITY);
                end else begin
                    o_raddr = r_red[IDX_W-1:0];
                    n_idx   = r_red[IDX_W-1:0];
                    n_cnt   = '0;
                    n_state = lphm_pkg::S_PROBE;
                end
            end
            lphm_pkg::S_PROBE: begin
                // read the next slot ahead so a miss moves on without waiting for a read
                o_raddr           = i_next_idx;
                n_rsp.found_value = '0;
                if (i_pres.hit || i_pres.empty || i_pres.last_probe) begin
                    n_done  = 1'b1;
                    n_state = lphm_pkg::S_IDLE;
                    if (i_pres.hit) begin
                        if (r_req.func == lphm_pkg::FUNC_INSERT) begin
                            o_wr.val_we  = 1'b1;
                            n_rsp.status = lphm_pkg::ST_UPDATED;
                        end else begin
                            n_rsp.status      = lphm_pkg::ST_FOUND;
                            n_rsp.found_value = i_rval;
                        end
                    end else if (r_req.func == lphm_pkg::FUNC_LOOKUP) begin
                        n_rsp.status = lphm_pkg::ST_NOT_FOUND;
                    end else if (i_pres.empty && (r_count < i_fill_limit)) begin
                        o_wr.key_we  = 1'b1;
                        o_wr.val_we  = 1'b1;
                        n_count      = r_count + lphm_pkg::CNT_W'(1);
                        n_rsp.status = lphm_pkg::ST_INSERTED;
                    end else begin
                        n_rsp.status = lphm_pkg::ST_FULL;
                    end
                    n_rsp.entry_count = n_count;
                end else begin
                    n_idx = i_next_idx;
                    n_cnt = i_next_cnt;
                end
            end
            default: begin
                n_state = lphm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idx  = r_idx;
    assign o_cnt  = r_cnt;
    assign o_key  = r_req.key;
    assign o_busy = (r_state != lphm_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== hw/rtl/linear_probe_hash_map.sv =====
// linear probing key/value table
//
// request channel: start with i_req (func, key, value, hash_index) is taken
// at a clock edge where busy is low. func insert stores or updates the value,
// func lookup returns the stored value. o_done strobes o_rsp (status,
// found_value, entry_count) for exactly one cycle; it cannot be held off.
//
// sequence: a zero key answers in the cycle after the request. otherwise
// S_REDUCE reduces hash_index modulo CAPACITY by repeated subtraction to
// the start slot (none at CAPACITY >= 1024); S_PROBE then does one key
// memory read per cycle, next slot read ahead, and the response follows in
// the cycle after the last probe. busy is high from accepting a probed
// request to the response cycle, in which the next request may already be taken.
//
// reset: the key memory is swept to empty slot by slot, busy is high
// meanwhile. fill_limit (apb, byte address 0) resets to 614 and may be
// written at any time; the value memory is not cleared.
module linear_probe_hash_map #(
    parameter int CAPACITY = lphm_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lphm_pkg::t_req                i_req,
    output logic                          o_done,
    output lphm_pkg::t_rsp                o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lphm_pkg::PADDR_W-1:0]  paddr,
    input  logic [lphm_pkg::PDATA_W-1:0]  pwdata,
    output logic [lphm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [lphm_pkg::CNT_W-1:0] r_fill_limit;
    logic                       reg_sel;

    logic [IDX_W-1:0]           idx, cnt, next_idx, next_cnt, waddr, raddr;
    logic [lphm_pkg::KEY_W-1:0] key, rkey, wkey;
    logic [lphm_pkg::VAL_W-1:0] rval, wval;
    lphm_pkg::t_wr_ctl          wr;
    lphm_pkg::t_probe_res       pres;

    assign reg_sel = (paddr[2] == lphm_pkg::REG_FILL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= lphm_pkg::FILL_LIMIT_RST;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_fill_limit <= pwdata[lphm_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? lphm_pkg::PDATA_W'(r_fill_limit) : '0;

    lphm_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_waddr (waddr),
        .i_wkey  (wkey),
        .i_wval  (wval),
        .i_raddr (raddr),
        .o_rkey  (rkey),
        .o_rval  (rval)
    );

    lphm_probe #(.CAPACITY(CAPACITY)) u_probe (
        .i_idx        (idx),
        .i_cnt        (cnt),
        .i_stored_key (rkey),
        .i_key        (key),
        .o_next_idx   (next_idx),
        .o_next_cnt   (next_cnt),
        .o_res        (pres)
    );

    lphm_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_fill_limit (r_fill_limit),
        .i_rkey       (rkey),
        .i_rval       (rval),
        .i_next_idx   (next_idx),
        .i_next_cnt   (next_cnt),
        .i_pres       (pres),
        .o_idx        (idx),
        .o_cnt        (cnt),
        .o_key        (key),
        .o_wr         (wr),
        .o_waddr      (waddr),
        .o_wkey       (wkey),
        .o_wval       (wval),
        .o_raddr      (raddr),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== hw/rtl/lphm_chk.sv =====
module lphm_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input lphm_pkg::t_req i_req,
    input logic           o_done,
    input lphm_pkg::t_rsp o_rsp
);

    // reset starts the clearing sweep
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.key == '0)) |=>
            (o_done && (o_rsp.status == lphm_pkg::ST_ZERO_KEY)))
        else $error("zero key request not flagged");

    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.key != '0)) |=> !o_done)
        else $error("response too early for a probed request");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != lphm_pkg::ST_FOUND)) |-> (o_rsp.found_value == '0))
        else $error("found_value nonzero without a hit");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == lphm_pkg::ST_INSERTED)) |-> (o_rsp.entry_count != '0))
        else $error("insert reported with empty table");

endmodule

bind linear_probe_hash_map lphm_chk u_lphm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
